/* rtl/core/cpt_pkg.sv */
`default_nettype none

package cpt_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int DOT_W   = 2 * DIFF_W + 2;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int TRIP_W  = 2 * CROSS_W + 2;
	localparam int DEN_W   = TRIP_W + 2;
	localparam int NUM_W   = TRIP_W + DIFF_W + 2;
	localparam int QRES_W  = NUM_W + 2;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [2:0] REG_A    = 3'd0;
	localparam logic [2:0] REG_B    = 3'd1;
	localparam logic [2:0] REG_C    = 3'd2;
	localparam logic [2:0] REG_AB   = 3'd3;
	localparam logic [2:0] REG_BC   = 3'd4;
	localparam logic [2:0] REG_CA   = 3'd5;
	localparam logic [2:0] REG_FACE = 3'd6;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic signed [TRIP_W-1:0]  trip_t;
	typedef logic signed [DEN_W-1:0]   den_t;
	typedef logic signed [NUM_W-1:0]   num_t;

	typedef struct packed {
		coord_t p_x;
		coord_t p_y;
		coord_t p_z;
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
	} query_t;

	typedef struct packed {
		coord_t     q_x;
		coord_t     q_y;
		coord_t     q_z;
		logic [2:0] region;
		logic       degenerate;
	} result_t;

	// Three signed factors that weight m0, m1, m2 on one axis.
	typedef struct packed {
		diff_t f0;
		diff_t f1;
		diff_t f2;
	} fac_t;

	// One classified item. A direct item already holds its answer.
	typedef struct packed {
		logic       direct;
		logic [2:0] region;
		logic       degenerate;
		coord_t     pt_x;
		coord_t     pt_y;
		coord_t     pt_z;
		trip_t      m0;
		trip_t      m1;
		trip_t      m2;
		fac_t       fac_x;
		fac_t       fac_y;
		fac_t       fac_z;
		coord_t     base_x;
		coord_t     base_y;
		coord_t     base_z;
		den_t       den;
	} job_t;

	typedef struct packed {
		logic             empty;
		logic [Q_AW:0]    count;
	} qstat_t;

endpackage

`default_nettype wire

/* rtl/core/cpt_front.sv */
`default_nettype none

module cpt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  cpt_pkg::query_t query,
	output logic            push,
	output cpt_pkg::job_t   job,
	output logic [1:0]      inflight
);
	import cpt_pkg::*;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		cross_t x;
		cross_t y;
		cross_t z;
	} cvec_t;

	function automatic dvec_t vsub(coord_t ux, coord_t uy, coord_t uz,
		coord_t vx, coord_t vy, coord_t vz);
		dvec_t r;
		r.x = diff_t'(ux) - diff_t'(vx);
		r.y = diff_t'(uy) - diff_t'(vy);
		r.z = diff_t'(uz) - diff_t'(vz);
		return r;
	endfunction

	function automatic dot_t vdot(dvec_t u, dvec_t v);
		return dot_t'(u.x) * dot_t'(v.x) + dot_t'(u.y) * dot_t'(v.y)
			+ dot_t'(u.z) * dot_t'(v.z);
	endfunction

	function automatic cvec_t vcross(dvec_t u, dvec_t v);
		cvec_t r;
		r.x = cross_t'(u.y) * cross_t'(v.z) - cross_t'(u.z) * cross_t'(v.y);
		r.y = cross_t'(u.z) * cross_t'(v.x) - cross_t'(u.x) * cross_t'(v.z);
		r.z = cross_t'(u.x) * cross_t'(v.y) - cross_t'(u.y) * cross_t'(v.x);
		return r;
	endfunction

	function automatic trip_t tdot(cvec_t u, cvec_t v);
		return trip_t'(u.x) * trip_t'(v.x) + trip_t'(u.y) * trip_t'(v.y)
			+ trip_t'(u.z) * trip_t'(v.z);
	endfunction

	// Stage 1: edge and point differences.
	logic   v_s1;
	query_t qry_s1;
	dvec_t  ab_s1, ac_s1, bc_s1, ba_s1, ca_s1, cb_s1, pa_s1, pb_s1, pc_s1;

	// Stage 2: dot products and cross products.
	logic   v_s2;
	query_t qry_s2;
	dvec_t  ab_s2, ac_s2, bc_s2;
	dot_t   snom_s2, sden_s2, tnom_s2, tden_s2, unom_s2, uden_s2;
	cvec_t  n_s2, xab_s2, xbc_s2, xca_s2;

	// Stage 3: triple products.
	logic   v_s3;
	query_t qry_s3;
	dvec_t  ab_s3, ac_s3, bc_s3;
	dot_t   snom_s3, sden_s3, tnom_s3, tden_s3, unom_s3, uden_s3;
	trip_t  va_s3, vb_s3, vc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		qry_s1 <= query;
		ab_s1  <= vsub(query.b_x, query.b_y, query.b_z, query.a_x, query.a_y, query.a_z);
		ac_s1  <= vsub(query.c_x, query.c_y, query.c_z, query.a_x, query.a_y, query.a_z);
		bc_s1  <= vsub(query.c_x, query.c_y, query.c_z, query.b_x, query.b_y, query.b_z);
		ba_s1  <= vsub(query.a_x, query.a_y, query.a_z, query.b_x, query.b_y, query.b_z);
		ca_s1  <= vsub(query.a_x, query.a_y, query.a_z, query.c_x, query.c_y, query.c_z);
		cb_s1  <= vsub(query.b_x, query.b_y, query.b_z, query.c_x, query.c_y, query.c_z);
		pa_s1  <= vsub(query.p_x, query.p_y, query.p_z, query.a_x, query.a_y, query.a_z);
		pb_s1  <= vsub(query.p_x, query.p_y, query.p_z, query.b_x, query.b_y, query.b_z);
		pc_s1  <= vsub(query.p_x, query.p_y, query.p_z, query.c_x, query.c_y, query.c_z);

		qry_s2  <= qry_s1;
		ab_s2   <= ab_s1;
		ac_s2   <= ac_s1;
		bc_s2   <= bc_s1;
		snom_s2 <= vdot(pa_s1, ab_s1);
		sden_s2 <= vdot(pb_s1, ba_s1);
		tnom_s2 <= vdot(pa_s1, ac_s1);
		tden_s2 <= vdot(pc_s1, ca_s1);
		unom_s2 <= vdot(pb_s1, bc_s1);
		uden_s2 <= vdot(pc_s1, cb_s1);
		n_s2    <= vcross(ab_s1, ac_s1);
		// (A-P)x(B-P) equals (P-A)x(P-B), and likewise for the other two.
		xab_s2  <= vcross(pa_s1, pb_s1);
		xbc_s2  <= vcross(pb_s1, pc_s1);
		xca_s2  <= vcross(pc_s1, pa_s1);

		qry_s3  <= qry_s2;
		ab_s3   <= ab_s2;
		ac_s3   <= ac_s2;
		bc_s3   <= bc_s2;
		snom_s3 <= snom_s2;
		sden_s3 <= sden_s2;
		tnom_s3 <= tnom_s2;
		tden_s3 <= tden_s2;
		unom_s3 <= unom_s2;
		uden_s3 <= uden_s2;
		vc_s3   <= tdot(n_s2, xab_s2);
		va_s3   <= tdot(n_s2, xbc_s2);
		vb_s3   <= tdot(n_s2, xca_s2);
	end

	// Region classification, in the order of the Voronoi test.
	logic snom_le, sden_le, tnom_le, tden_le, unom_le, uden_le;
	logic snom_ge, sden_ge, tnom_ge, tden_ge, unom_ge, uden_ge;
	logic va_le, vb_le, vc_le;
	den_t den_ab, den_bc, den_ca, den_face;

	always_comb begin
		snom_le = snom_s3[DOT_W-1] || (snom_s3 == '0);
		sden_le = sden_s3[DOT_W-1] || (sden_s3 == '0);
		tnom_le = tnom_s3[DOT_W-1] || (tnom_s3 == '0);
		tden_le = tden_s3[DOT_W-1] || (tden_s3 == '0);
		unom_le = unom_s3[DOT_W-1] || (unom_s3 == '0);
		uden_le = uden_s3[DOT_W-1] || (uden_s3 == '0);
		snom_ge = !snom_s3[DOT_W-1];
		sden_ge = !sden_s3[DOT_W-1];
		tnom_ge = !tnom_s3[DOT_W-1];
		tden_ge = !tden_s3[DOT_W-1];
		unom_ge = !unom_s3[DOT_W-1];
		uden_ge = !uden_s3[DOT_W-1];
		va_le   = va_s3[TRIP_W-1] || (va_s3 == '0);
		vb_le   = vb_s3[TRIP_W-1] || (vb_s3 == '0);
		vc_le   = vc_s3[TRIP_W-1] || (vc_s3 == '0);
		den_ab   = den_t'(snom_s3) + den_t'(sden_s3);
		den_bc   = den_t'(unom_s3) + den_t'(uden_s3);
		den_ca   = den_t'(tnom_s3) + den_t'(tden_s3);
		den_face = den_t'(va_s3) + den_t'(vb_s3) + den_t'(vc_s3);

		job            = '0;
		job.direct     = 1'b1;
		job.pt_x       = qry_s3.a_x;
		job.pt_y       = qry_s3.a_y;
		job.pt_z       = qry_s3.a_z;
		priority if (snom_le && tnom_le) begin
			job.region = REG_A;
		end else if (sden_le && unom_le) begin
			job.region = REG_B;
			job.pt_x   = qry_s3.b_x;
			job.pt_y   = qry_s3.b_y;
			job.pt_z   = qry_s3.b_z;
		end else if (tden_le && uden_le) begin
			job.region = REG_C;
			job.pt_x   = qry_s3.c_x;
			job.pt_y   = qry_s3.c_y;
			job.pt_z   = qry_s3.c_z;
		end else if (vc_le && snom_ge && sden_ge) begin
			job.region     = REG_AB;
			job.degenerate = (den_ab == '0);
			job.direct     = (den_ab == '0);
			job.m0         = trip_t'(snom_s3);
			job.fac_x.f0   = ab_s3.x;
			job.fac_y.f0   = ab_s3.y;
			job.fac_z.f0   = ab_s3.z;
			job.base_x     = qry_s3.a_x;
			job.base_y     = qry_s3.a_y;
			job.base_z     = qry_s3.a_z;
			job.den        = den_ab;
		end else if (va_le && unom_ge && uden_ge) begin
			job.region     = REG_BC;
			job.degenerate = (den_bc == '0);
			job.direct     = (den_bc == '0);
			job.m0         = trip_t'(unom_s3);
			job.fac_x.f0   = bc_s3.x;
			job.fac_y.f0   = bc_s3.y;
			job.fac_z.f0   = bc_s3.z;
			job.base_x     = qry_s3.b_x;
			job.base_y     = qry_s3.b_y;
			job.base_z     = qry_s3.b_z;
			job.den        = den_bc;
		end else if (vb_le && tnom_ge && tden_ge) begin
			job.region     = REG_CA;
			job.degenerate = (den_ca == '0);
			job.direct     = (den_ca == '0);
			job.m0         = trip_t'(tnom_s3);
			job.fac_x.f0   = ac_s3.x;
			job.fac_y.f0   = ac_s3.y;
			job.fac_z.f0   = ac_s3.z;
			job.base_x     = qry_s3.a_x;
			job.base_y     = qry_s3.a_y;
			job.base_z     = qry_s3.a_z;
			job.den        = den_ca;
		end else begin
			job.region     = REG_FACE;
			job.degenerate = (den_face == '0);
			job.direct     = (den_face == '0);
			job.m0         = va_s3;
			job.m1         = vb_s3;
			job.m2         = vc_s3;
			job.fac_x      = '{f0: diff_t'(qry_s3.a_x), f1: diff_t'(qry_s3.b_x),
				f2: diff_t'(qry_s3.c_x)};
			job.fac_y      = '{f0: diff_t'(qry_s3.a_y), f1: diff_t'(qry_s3.b_y),
				f2: diff_t'(qry_s3.c_y)};
			job.fac_z      = '{f0: diff_t'(qry_s3.a_z), f1: diff_t'(qry_s3.b_z),
				f2: diff_t'(qry_s3.c_z)};
			job.den        = den_face;
		end
	end

	assign push     = v_s3;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3};

endmodule

`default_nettype wire

/* rtl/core/cpt_queue.sv */
`default_nettype none

module cpt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cpt_pkg::job_t    wr_job,
	input  logic             pop,
	output cpt_pkg::job_t    rd_job,
	output cpt_pkg::qstat_t  stat
);
	import cpt_pkg::*;

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{Q_AW{1'b0}}, push} - {{Q_AW{1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_job;
		end
	end

	assign rd_job     = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

endmodule

`default_nettype wire

/* rtl/core/cpt_back.sv */
`default_nettype none

module cpt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cpt_pkg::job_t    head,
	input  cpt_pkg::qstat_t  stat,
	output logic             pop,
	output logic             done,
	output cpt_pkg::result_t result
);
	import cpt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	typedef logic signed [QRES_W-1:0] qres_t;

	function automatic num_t pick(fac_t f, trip_t m0, trip_t m1, trip_t m2);
		num_t s;
		s = '0;
		if (f.f0[DIFF_W-1]) s = s + num_t'(m0);
		if (f.f1[DIFF_W-1]) s = s + num_t'(m1);
		if (f.f2[DIFF_W-1]) s = s + num_t'(m2);
		return s;
	endfunction

	function automatic coord_t sat(qres_t v);
		if (v > qres_t'(32'sd2 ** (COORD_W - 1) - 1))
			return {1'b0, {(COORD_W-1){1'b1}}};
		else if (v < -qres_t'(33'sd2 ** (COORD_W - 1)))
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return v[COORD_W-1:0];
	endfunction

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	result_t            result_q;
	logic [2:0]         region_q;
	trip_t              m0_q, m1_q, m2_q;
	logic [DEN_W-1:0]   dabs_q;
	logic               dneg_q;
	fac_t               fs_q   [3];
	coord_t             base_q [3];
	num_t               acc_q  [3];
	logic [NUM_W-1:0]   numa_q [3];
	logic               neg_q  [3];
	logic [DEN_W-1:0]   rem_q  [3];
	logic [NUM_W-1:0]   quo_q  [3];
	coord_t             out_c  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qres_t qs;
			qs = neg_q[k] ? -qres_t'({2'b00, quo_q[k]}) : qres_t'({2'b00, quo_q[k]});
			out_c[k] = sat(qs + qres_t'(base_q[k]));
		end
	end

	assign pop = (state_q == ST_IDLE) && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (!stat.empty) begin
						if (head.direct) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == CNT_W'(DIFF_W - 1)) begin
						state_q <= ST_PREP;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				result_q <= '{q_x: head.pt_x, q_y: head.pt_y, q_z: head.pt_z,
					region: head.region, degenerate: head.degenerate};
				region_q  <= head.region;
				m0_q      <= head.m0;
				m1_q      <= head.m1;
				m2_q      <= head.m2;
				dneg_q    <= head.den[DEN_W-1];
				dabs_q    <= head.den[DEN_W-1] ? DEN_W'(-head.den) : head.den;
				fs_q[0]   <= head.fac_x;
				fs_q[1]   <= head.fac_y;
				fs_q[2]   <= head.fac_z;
				base_q[0] <= head.base_x;
				base_q[1] <= head.base_y;
				base_q[2] <= head.base_z;
			end
			ST_MUL: begin
				// Shift-and-add over the factor bits, sign bit first with weight minus one.
				for (int k = 0; k < 3; k++) begin
					if (cnt_q == '0)
						acc_q[k] <= -pick(fs_q[k], m0_q, m1_q, m2_q);
					else
						acc_q[k] <= (acc_q[k] <<< 1) + pick(fs_q[k], m0_q, m1_q, m2_q);
					fs_q[k] <= fs_q[k] << 1;
				end
			end
			ST_PREP: begin
				for (int k = 0; k < 3; k++) begin
					numa_q[k] <= acc_q[k][NUM_W-1] ? NUM_W'(-acc_q[k]) : acc_q[k];
					neg_q[k]  <= acc_q[k][NUM_W-1] ^ dneg_q;
					rem_q[k]  <= '0;
					quo_q[k]  <= '0;
				end
			end
			ST_DIV: begin
				// Restoring division, one quotient bit per cycle on each axis.
				for (int k = 0; k < 3; k++) begin
					logic [DEN_W:0] rsh;
					rsh = {rem_q[k], numa_q[k][NUM_W-1]};
					if (rsh >= {1'b0, dabs_q}) begin
						rem_q[k] <= DEN_W'(rsh - {1'b0, dabs_q});
						quo_q[k] <= {quo_q[k][NUM_W-2:0], 1'b1};
					end else begin
						rem_q[k] <= rsh[DEN_W-1:0];
						quo_q[k] <= {quo_q[k][NUM_W-2:0], 1'b0};
					end
					numa_q[k] <= numa_q[k] << 1;
				end
			end
			ST_FIN: begin
				result_q <= '{q_x: out_c[0], q_y: out_c[1], q_z: out_c[2],
					region: region_q, degenerate: 1'b0};
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

/* rtl/core/closest_point_on_triangle_unit.sv */
// Channel  | Ports                  | Handshake
// ---------+------------------------+---------------------------------------------
// query    | start, busy, query     | word taken at a rising edge with start && !busy
// result   | done, result           | word valid for one cycle while done is high
//
// For a vertex or degenerate word, the edge that takes it loads the first front
// stage, and then come the second and third front stages, the queue write and
// the back result register, once the back part is done with earlier words.
// An edge or face word holds the back part for an issue step, the multiply steps
// over the factor bits, a prepare step, the divide steps and a finish step. The
// back part sets the sustained rate for edge and face words; vertex words can
// follow each other one per cycle while busy stays low. An eight-word queue sits
// between the two parts, and busy rises when the words in the queue and in the
// front pipeline together fill it. Reset is asynchronous and active low and clears
// all control state. The receiver cannot stall, so results never wait.
`default_nettype none

module closest_point_on_triangle_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cpt_pkg::query_t  query,
	output logic             done,
	output cpt_pkg::result_t result
);
	import cpt_pkg::*;

	logic       take;
	logic       push;
	logic       pop;
	job_t       wr_job;
	job_t       rd_job;
	qstat_t     qstat;
	logic [1:0] inflight;

	// Every word in the front pipeline has a reserved queue slot, so the queue
	// can never overflow no matter how long the back part is occupied.
	assign busy = ({1'b0, qstat.count} + {{Q_AW{1'b0}}, inflight})
		>= (Q_AW+2)'(Q_DEPTH);
	assign take = start && !busy;

	cpt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.query    (query),
		.push     (push),
		.job      (wr_job),
		.inflight (inflight)
	);

	cpt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (qstat)
	);

	cpt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (rd_job),
		.stat   (qstat),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> qstat.count != (Q_AW+1)'(Q_DEPTH))
		else $error("queue written while full");

	a_busy_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count == (Q_AW+1)'(Q_DEPTH) |-> busy)
		else $error("input open while queue full");

	a_deg_region: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.region != REG_A
			&& result.region != REG_B && result.region != REG_C)
		else $error("degenerate flag on a vertex region");

	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.region != 3'd7)
		else $error("region code out of range");

endmodule

`default_nettype wire

/* tb/closest_point_on_triangle_unit_tb.sv */
`default_nettype none

// Testbench for the closest point on triangle unit.
//
// Each word on the query channel holds a point P and a triangle A, B, C in
// signed Q8.8. The bench keeps its own predictor of the block. It computes
// every dot, cross and triple product exactly in 128-bit signed integers.
// These never exceed about 92 bits for 16-bit inputs. It classifies the
// point into a vertex, edge or face region in the same order as the block.
//
// Stimulus starts with a short table of directed words. Rows whose answer is
// obvious carry it typed in, and the rest go to the predictor. Random words
// follow. Most are small triangles, where all seven regions are hit often.
// Some use full-range values, and some build degenerate triangles on purpose.
// The sender idles at random, except for one long stretch with no idling.
// It waits for the block to drain completely between the directed and random words.
module closest_point_on_triangle_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpt_pkg::*;

	typedef logic signed [127:0] wint_t;
	typedef wint_t vec_t [3];

	typedef struct {
		query_t  q;
		bit      known;
		result_t r;
	} row_t;

	localparam int N_RANDOM = 880;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 150;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	query_t  query = '0;
	logic    done;
	result_t result;

	result_t expected_points [$];
	int      n_errors = 0;
	int      n_checked = 0;
	int      region_hits [8];
	int      n_degenerate = 0;
	int      stall_cycles = 0;
	bit      idle_allowed = 1'b1;

	closest_point_on_triangle_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.query(query),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	function automatic vec_t vsub(vec_t u, vec_t v);
		vec_t r;
		for (int i = 0; i < 3; i++)
			r[i] = u[i] - v[i];
		return r;
	endfunction

	function automatic wint_t vdot(vec_t u, vec_t v);
		return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
	endfunction

	function automatic vec_t vcross(vec_t u, vec_t v);
		vec_t r;
		r[0] = u[1] * v[2] - u[2] * v[1];
		r[1] = u[2] * v[0] - u[0] * v[2];
		r[2] = u[0] * v[1] - u[1] * v[0];
		return r;
	endfunction

	function automatic coord_t clamp_coord(wint_t v);
		if (v > 32767)
			return coord_t'(16'h7fff);
		if (v < -32768)
			return coord_t'(16'h8000);
		return coord_t'(v[15:0]);
	endfunction

	function automatic result_t point_word(vec_t v, logic [2:0] reg_code, logic deg);
		result_t r;
		r.q_x = clamp_coord(v[0]);
		r.q_y = clamp_coord(v[1]);
		r.q_z = clamp_coord(v[2]);
		r.region = reg_code;
		r.degenerate = deg;
		return r;
	endfunction

	// Interpolated point on one edge. A zero sum means the edge has no
	// length, and then the block falls back to vertex A with the flag set.
	function automatic result_t edge_point(vec_t base, vec_t dir, wint_t nom, wint_t den,
			logic [2:0] reg_code, vec_t a);
		vec_t q;
		if (den == 0)
			return point_word(a, reg_code, 1'b1);
		for (int i = 0; i < 3; i++)
			q[i] = base[i] + (nom * dir[i]) / den;
		return point_word(q, reg_code, 1'b0);
	endfunction

	function automatic result_t closest_point(query_t w);
		vec_t  p, a, b, c, ab, ac, bc, pa, pb, pc, n, q;
		wint_t snom, sdenom, tnom, tdenom, unom, udenom, va, vb, vc, den;
		p = '{w.p_x, w.p_y, w.p_z};
		a = '{w.a_x, w.a_y, w.a_z};
		b = '{w.b_x, w.b_y, w.b_z};
		c = '{w.c_x, w.c_y, w.c_z};
		ab = vsub(b, a);
		ac = vsub(c, a);
		bc = vsub(c, b);
		pa = vsub(p, a);
		pb = vsub(p, b);
		pc = vsub(p, c);
		snom = vdot(pa, ab);
		sdenom = vdot(pb, vsub(a, b));
		tnom = vdot(pa, ac);
		tdenom = vdot(pc, vsub(a, c));
		if (snom <= 0 && tnom <= 0)
			return point_word(a, REG_A, 1'b0);
		unom = vdot(pb, bc);
		udenom = vdot(pc, vsub(b, c));
		if (sdenom <= 0 && unom <= 0)
			return point_word(b, REG_B, 1'b0);
		if (tdenom <= 0 && udenom <= 0)
			return point_word(c, REG_C, 1'b0);
		n = vcross(ab, ac);
		vc = vdot(n, vcross(vsub(a, p), vsub(b, p)));
		if (vc <= 0 && snom >= 0 && sdenom >= 0)
			return edge_point(a, ab, snom, snom + sdenom, REG_AB, a);
		va = vdot(n, vcross(vsub(b, p), vsub(c, p)));
		if (va <= 0 && unom >= 0 && udenom >= 0)
			return edge_point(b, bc, unom, unom + udenom, REG_BC, a);
		vb = vdot(n, vcross(vsub(c, p), vsub(a, p)));
		if (vb <= 0 && tnom >= 0 && tdenom >= 0)
			return edge_point(a, ac, tnom, tnom + tdenom, REG_CA, a);
		den = va + vb + vc;
		if (den == 0)
			return point_word(a, REG_FACE, 1'b1);
		for (int i = 0; i < 3; i++)
			q[i] = (va * a[i] + vb * b[i] + vc * c[i]) / den;
		return point_word(q, REG_FACE, 1'b0);
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic coord_t near_coord(int span);
		return coord_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic query_t make_query(int px, int py, int pz, int ax, int ay, int az,
			int bx, int by, int bz, int cx, int cy, int cz);
		return '{coord_t'(px), coord_t'(py), coord_t'(pz), coord_t'(ax), coord_t'(ay),
			coord_t'(az), coord_t'(bx), coord_t'(by), coord_t'(bz), coord_t'(cx),
			coord_t'(cy), coord_t'(cz)};
	endfunction

	// Most words are small triangles, where every region is reached often.
	// The rest use full-range values or are degenerate by construction.
	function automatic query_t random_query();
		query_t w;
		int     mode;
		int     k;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 12; i++)
			w[i*16 +: 16] = near_coord(1024);
		case (mode)
			5: begin
				w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			end
			6: begin
				// A and B coincide, so edge AB has no length.
				w.b_x = w.a_x;
				w.b_y = w.a_y;
				w.b_z = w.a_z;
			end
			7: begin
				// C lies on the line through A and B.
				k = $urandom_range(0, 4) - 2;
				w.c_x = coord_t'(w.a_x + k * (w.b_x - w.a_x));
				w.c_y = coord_t'(w.a_y + k * (w.b_y - w.a_y));
				w.c_z = coord_t'(w.a_z + k * (w.b_z - w.a_z));
			end
			8: begin
				// P close to the centroid, which favors the face region.
				w.p_x = coord_t'((w.a_x + w.b_x + w.c_x) / 3 + near_coord(64));
				w.p_y = coord_t'((w.a_y + w.b_y + w.c_y) / 3 + near_coord(64));
				w.p_z = coord_t'((w.a_z + w.b_z + w.c_z) / 3 + near_coord(64));
			end
			9: begin
				// All three vertices coincide.
				w.b_x = w.a_x;
				w.b_y = w.a_y;
				w.b_z = w.a_z;
				w.c_x = w.a_x;
				w.c_y = w.a_y;
				w.c_z = w.a_z;
			end
			default: begin
			end
		endcase
		return w;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	// Drives one word. It changes on the falling edge and counts as accepted
	// at the rising edge where busy is low. Random idle cycles may come
	// before the word, unless idling is switched off.
	task automatic send_word(query_t w, bit known, result_t want);
		bit taken;
		taken = 1'b0;
		@(negedge clk);
		while (idle_allowed && $urandom_range(0, 99) < 19) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		query = w;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1'b1;
				expected_points.push_back(known ? want : closest_point(w));
			end else begin
				@(negedge clk);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Result checking and watchdog
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				$display("[%0t] result word arrived with nothing expected", $realtime);
				n_errors++;
			end else begin
				want = expected_points.pop_front();
				n_checked++;
				region_hits[want.region]++;
				if (want.degenerate)
					n_degenerate++;
				if (result.q_x !== want.q_x)
					report_mismatch("q_x", result.q_x, want.q_x);
				if (result.q_y !== want.q_y)
					report_mismatch("q_y", result.q_y, want.q_y);
				if (result.q_z !== want.q_z)
					report_mismatch("q_z", result.q_z, want.q_z);
				if (result.region !== want.region)
					report_mismatch("region", result.region, want.region);
				if (result.degenerate !== want.degenerate)
					report_mismatch("degenerate", result.degenerate, want.degenerate);
			end
		end
	end

	// The watchdog counts cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", expected_points.size());
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		row_t    rows [$];
		result_t none;
		none = '0;

		// Rows with a typed answer: P on A, full-scale corners, a point beyond vertex A, and a
		// zero-length edge AB with P between A and C, which must give A with the flag set.
		rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{16'sd0, 16'sd0, 16'sd0, REG_A, 1'b0}});
		rows.push_back('{make_query(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767, 32767, 32767), 1'b1,
			'{16'sh7fff, 16'sh7fff, 16'sh7fff, REG_A, 1'b0}});
		rows.push_back('{make_query(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, -32768, -32768), 1'b1,
			'{16'sh8000, 16'sh8000, 16'sh8000, REG_A, 1'b0}});
		rows.push_back('{make_query(128, 0, 0, 0, 0, 0, 0, 0, 0, 256, 0, 0), 1'b1,
			'{16'sd0, 16'sd0, 16'sd0, REG_AB, 1'b1}});
		rows.push_back('{make_query(-300, -300, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1'b1,
			'{16'sd0, 16'sd0, 16'sd0, REG_A, 1'b0}});
		// Remaining rows go through the predictor: vertices B and C, each edge and the face
		// region, a collinear triangle, a triangle whose vertices coincide, and extreme values.
		rows.push_back('{make_query(600, -50, 10, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1'b0, none});
		rows.push_back('{make_query(-40, 700, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1'b0, none});
		rows.push_back('{make_query(100, -90, 30, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1'b0, none});
		rows.push_back('{make_query(200, 200, -5, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1'b0, none});
		rows.push_back('{make_query(-77, 100, 1, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1'b0, none});
		rows.push_back('{make_query(60, 70, 512, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1'b0, none});
		rows.push_back('{make_query(50, 50, 50, 0, 0, 0, 100, 100, 100, 300, 300, 300),
			1'b0, none});
		rows.push_back('{make_query(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768, -32768, -32768, 32767), 1'b0, none});
		rows.push_back('{make_query(-32768, 32767, 0, 32767, -32768, 32767,
			-32768, -32768, 32767, 32767, 32767, -32768), 1'b0, none});
		rows.push_back('{make_query(0, 0, 0, -32768, -32768, 0, 32767, -32768, 0,
			0, 32767, 0), 1'b0, none});
		rows.push_back('{make_query(1, 2, 3, 5, 5, 5, 5, 5, 5, 5, 5, 5), 1'b0, none});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_word(rows[i].q, rows[i].known, rows[i].r);

		// Let the block drain completely before the random part.
		@(negedge clk);
		start = 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			idle_allowed = !(i >= 300 && i < 500);
			send_word(random_query(), 1'b0, none);
		end
		@(negedge clk);
		start = 1'b0;

		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d words: A %0d, B %0d, C %0d, AB %0d, BC %0d, CA %0d, face %0d",
			n_checked, region_hits[0], region_hits[1], region_hits[2], region_hits[3],
			region_hits[4], region_hits[5], region_hits[6]);
		$display("degenerate triangles among them: %0d, mismatches: %0d",
			n_degenerate, n_errors);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
